// ===== rtl/rule_chain_value_transform_core_defines.svh =====
// ---------------------------------------------------------------------------
// Rule chain value transform: assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef RULE_CHAIN_VALUE_TRANSFORM_CORE_DEFINES_SVH
`define RULE_CHAIN_VALUE_TRANSFORM_CORE_DEFINES_SVH

// consequent checked in the same cycle
`define RCVT_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// consequent checked in the next cycle
`define RCVT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rcvt_pkg.sv =====
// ---------------------------------------------------------------------------
// Rule chain value transform package
// Operation and rule kind codes, register indexes, control/status types.
// ---------------------------------------------------------------------------
`default_nettype none

package rcvt_pkg;

   localparam logic [2:0] OP_BIND  = 3'd0;
   localparam logic [2:0] OP_RULE  = 3'd1;
   localparam logic [2:0] OP_SET   = 3'd2;
   localparam logic [2:0] OP_EVAL  = 3'd3;
   localparam logic [2:0] OP_FETCH = 3'd4;

   localparam logic [4:0] KIND_SRA_C = 5'd0;
   localparam logic [4:0] KIND_INV   = 5'd1;
   localparam logic [4:0] KIND_SUB_C = 5'd2;
   localparam logic [4:0] KIND_ADD_C = 5'd3;
   localparam logic [4:0] KIND_SHL_C = 5'd4;
   localparam logic [4:0] KIND_AND_C = 5'd5;
   localparam logic [4:0] KIND_OR_C  = 5'd6;
   localparam logic [4:0] KIND_SRA_B = 5'd9;
   localparam logic [4:0] KIND_SUB_B = 5'd10;
   localparam logic [4:0] KIND_ADD_B = 5'd11;
   localparam logic [4:0] KIND_SHL_B = 5'd12;
   localparam logic [4:0] KIND_AND_B = 5'd13;
   localparam logic [4:0] KIND_OR_B  = 5'd14;
   localparam logic [4:0] KIND_MUL_C = 5'd15;
   localparam logic [4:0] KIND_DIV_C = 5'd16;
   localparam logic [4:0] KIND_MUL_B = 5'd17;
   localparam logic [4:0] KIND_DIV_B = 5'd18;
   localparam logic [4:0] KIND_B15   = 5'd19;
   localparam logic [4:0] KIND_REM_B = 5'd20;
   localparam logic [4:0] KIND_REM_C = 5'd21;
   localparam logic [4:0] KIND_ABS   = 5'd22;
   localparam logic [4:0] KIND_NEG   = 5'd23;

   localparam logic [3:0] CSR_ACTIVE_SLOTS = 4'd0;
   localparam logic [3:0] CSR_ACTIVE_RULES = 4'd1;

   localparam int unsigned VAR_BASE  = 257;
   localparam int unsigned BYTE_MAX  = 255;
   localparam logic [31:0] BIT15     = 32'b1000000000000000;
   localparam logic [31:0] BYTE_MASK = 32'hFF;
   localparam int unsigned DIV_STEPS = 32;

   typedef struct packed {
      logic [8:0]  var_num;
      logic [15:0] dev;
      logic [4:0]  kind;
      logic [31:0] arg;
   } rule_type;

   typedef struct packed {
      logic load_req;
      logic bind_wr;
      logic rule_wr;
      logic slot_rd;
      logic slot_search;
      logic byte_rd_own;
      logic set_rerr;
      logic set_found;
      logic store_wr;
      logic take_id;
      logic rule_rd;
      logic b_rd;
      logic exec;
      logic div_start;
      logic div_take;
      logic idx_inc;
      logic clr_wr;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       slot_ok;
      logic       var_ok;
      logic       slots_none;
      logic       slot_last;
      logic       slot_match;
      logic       rules_none;
      logic       rule_last;
      logic       rule_hit;
      logic       div_go;
      logic       div_done;
      logic       div_busy;
      logic       clr_last;
   } stat_type;

endpackage

`default_nettype wire

// ===== rtl/rcvt_channels.sv =====
// ---------------------------------------------------------------------------
// Rule chain value transform channels
// Request, response and register write channels with valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface rcvt_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         operation;
   logic [3:0]         device_slot;
   logic [15:0]        sensor_id;
   logic [8:0]         var_number;
   logic signed [31:0] value;
   logic [5:0]         rule_index;
   logic [4:0]         rule_kind;
   logic signed [31:0] argument;

   modport source (output valid, operation, device_slot, sensor_id, var_number, value,
                   rule_index, rule_kind, argument, input ready);
   modport sink   (input valid, operation, device_slot, sensor_id, var_number, value,
                   rule_index, rule_kind, argument, output ready);
endinterface

interface rcvt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_value;
   logic               found;
   logic               divide_by_zero;
   logic               range_error;

   modport source (output valid, result_value, found, divide_by_zero, range_error,
                   input ready);
   modport sink   (input valid, result_value, found, divide_by_zero, range_error,
                   output ready);
endinterface

interface rcvt_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  reg_index;
   logic [31:0] wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rcvt_div.sv =====
// ---------------------------------------------------------------------------
// Rule chain value transform divider
// Signed 32-bit restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module rcvt_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   input  wire logic        want_rem,
   output logic             busy,
   output logic             done,
   output logic [31:0]      result
);
   import rcvt_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] ub_ff, ub_in;
   logic        neg_q_ff, neg_q_in;
   logic        neg_r_ff, neg_r_in;
   logic        sel_r_ff, sel_r_in;
   logic [31:0] res_ff, res_in;

   logic [32:0] shifted;
   logic [33:0] diff;
   logic        ge;
   logic [31:0] rem_step, quo_step;

   always_comb begin
      shifted  = {rem_ff, quo_ff[31]};
      diff     = {1'b0, shifted} - {2'b00, ub_ff};
      ge       = ~diff[33];
      rem_step = ge ? diff[31:0] : shifted[31:0];
      quo_step = {quo_ff[30:0], ge};

      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      ub_in    = ub_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      sel_r_in = sel_r_ff;
      res_in   = res_ff;

      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         rem_in   = '0;
         quo_in   = dividend[31] ? 32'd0 - dividend : dividend;
         ub_in    = divisor[31] ? 32'd0 - divisor : divisor;
         neg_q_in = dividend[31] ^ divisor[31];
         neg_r_in = dividend[31];
         sel_r_in = want_rem;
      end else if (busy_ff) begin
         rem_in = rem_step;
         quo_in = quo_step;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (sel_r_ff) begin
               res_in = neg_r_ff ? 32'd0 - rem_step : rem_step;
            end else begin
               res_in = neg_q_ff ? 32'd0 - quo_step : quo_step;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      ub_ff    <= ub_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      sel_r_ff <= sel_r_in;
      res_ff   <= res_in;
   end

   assign busy   = busy_ff;
   assign done   = done_ff;
   assign result = res_ff;

endmodule

`default_nettype wire

// ===== rtl/rcvt_ctrl.sv =====
// ---------------------------------------------------------------------------
// Rule chain value transform controller
// Sequences store clearing, request decode, slot search and the rule walk.
// ---------------------------------------------------------------------------
`default_nettype none

module rcvt_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire rcvt_pkg::stat_type st,
   output rcvt_pkg::cmd_type       cmd
);
   import rcvt_pkg::*;

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_DECODE = 4'd2;
   localparam logic [3:0] ST_SR_RD  = 4'd3;
   localparam logic [3:0] ST_SR_CMP = 4'd4;
   localparam logic [3:0] ST_EV_INI = 4'd5;
   localparam logic [3:0] ST_RU_RD  = 4'd6;
   localparam logic [3:0] ST_RU_CHK = 4'd7;
   localparam logic [3:0] ST_RU_EXE = 4'd8;
   localparam logic [3:0] ST_RU_DIV = 4'd9;
   localparam logic [3:0] ST_FIN    = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;

      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (st.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (st.op)
               OP_BIND: begin
                  cmd.bind_wr = 1'b1;
                  state_in    = ST_FIN;
               end
               OP_RULE: begin
                  cmd.rule_wr = 1'b1;
                  state_in    = ST_FIN;
               end
               OP_SET: begin
                  state_in = st.slots_none ? ST_FIN : ST_SR_RD;
               end
               OP_EVAL, OP_FETCH: begin
                  if (st.op == OP_FETCH && !st.var_ok) begin
                     cmd.set_rerr = 1'b1;
                     state_in     = ST_FIN;
                  end else begin
                     cmd.slot_rd     = 1'b1;
                     cmd.byte_rd_own = 1'b1;
                     state_in        = ST_EV_INI;
                  end
               end
               default: begin
                  state_in = ST_FIN;
               end
            endcase
         end
         ST_SR_RD: begin
            cmd.slot_rd     = 1'b1;
            cmd.slot_search = 1'b1;
            state_in        = ST_SR_CMP;
         end
         ST_SR_CMP: begin
            if (st.slot_match) begin
               cmd.set_found = 1'b1;
               cmd.store_wr  = 1'b1;
               state_in      = ST_FIN;
            end else if (st.slot_last) begin
               state_in = ST_FIN;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_SR_RD;
            end
         end
         ST_EV_INI: begin
            cmd.take_id = 1'b1;
            state_in    = (!st.slot_ok || st.rules_none) ? ST_FIN : ST_RU_RD;
         end
         ST_RU_RD: begin
            cmd.rule_rd = 1'b1;
            state_in    = ST_RU_CHK;
         end
         ST_RU_CHK: begin
            cmd.b_rd = 1'b1;
            if (st.rule_hit) begin
               state_in = ST_RU_EXE;
            end else if (st.rule_last) begin
               state_in = ST_FIN;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_RU_RD;
            end
         end
         ST_RU_EXE: begin
            if (st.div_go) begin
               cmd.div_start = 1'b1;
               state_in      = ST_RU_DIV;
            end else begin
               cmd.exec = 1'b1;
               if (st.rule_last) begin
                  state_in = ST_FIN;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_RU_RD;
               end
            end
         end
         ST_RU_DIV: begin
            if (st.div_done) begin
               cmd.div_take = 1'b1;
               if (st.rule_last) begin
                  state_in = ST_FIN;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_RU_RD;
               end
            end
         end
         ST_FIN: begin
            // hold the finished request until the output register frees up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/rcvt_datapath.sv =====
// ---------------------------------------------------------------------------
// Rule chain value transform datapath
// Tables, variable store, registers, rule ALU, divider and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module rcvt_datapath #(
   parameter int RULE_DEPTH     = 64,
   parameter int SLOT_COUNT     = 16,
   parameter int VARIABLE_COUNT = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rcvt_pkg::cmd_type  cmd,
   output rcvt_pkg::stat_type      st,
   input  wire logic [2:0]         req_operation,
   input  wire logic [3:0]         req_device_slot,
   input  wire logic [15:0]        req_sensor_id,
   input  wire logic [8:0]         req_var_number,
   input  wire logic [31:0]        req_value,
   input  wire logic [5:0]         req_rule_index,
   input  wire logic [4:0]         req_rule_kind,
   input  wire logic [31:0]        req_argument,
   input  wire logic               csr_wr,
   input  wire logic [3:0]         csr_index,
   input  wire logic [31:0]        csr_data,
   output logic [31:0]             rsp_result_value,
   output logic                    rsp_found,
   output logic                    rsp_divide_by_zero,
   output logic                    rsp_range_error
);
   import rcvt_pkg::*;

   localparam int STORE_DEPTH = SLOT_COUNT * VARIABLE_COUNT;
   localparam int RULE_AW     = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
   localparam int SLOT_AW     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STORE_DEPTH + RULE_DEPTH + 1);
   localparam logic [31:0] VAR_LAST = 32'(VAR_BASE - 1 + VARIABLE_COUNT);

   rule_type    rule_mem [RULE_DEPTH];
   logic [15:0] slot_mem [SLOT_COUNT];
   logic [7:0]  store_mem [STORE_DEPTH];

   rule_type    rule_rd_ff;
   logic [15:0] slot_rd_ff;
   logic [7:0]  store_rd_ff;
   logic        byte_ok_ff;

   logic [2:0]       op_ff;
   logic [3:0]       slot_ff;
   logic [15:0]      dev_ff;
   logic [8:0]       var_ff;
   logic [5:0]       ridx_ff;
   logic [4:0]       kind_ff;
   logic [31:0]      arg_ff;
   logic [31:0]      acc_ff, acc_in;
   logic [15:0]      id_ff;
   logic             found_ff, dz_ff, rerr_ff;
   logic [CNT_W-1:0] idx_ff;
   logic [4:0]       aslots_ff;
   logic [6:0]       arules_ff;

   logic [31:0] rsp_value_ff;
   logic        rsp_found_ff, rsp_dz_ff, rsp_rerr_ff;

   logic [31:0] slot_ext, var_ext, ridx_ext, idx_ext;
   logic [31:0] own_addr, set_addr, b_addr;
   logic [31:0] n_slots, n_rules;
   logic        slot_ok, var_ok, arg_ok;
   logic [7:0]  byte_val;
   logic [31:0] b_op, c_op, divisor;
   logic        is_div, want_rem;
   logic [31:0] alu_res, mul_c, mul_b, rsp_value_in;
   logic        div_busy, div_done;
   logic [31:0] div_result;

   always_comb begin
      slot_ext = {28'd0, slot_ff};
      var_ext  = {23'd0, var_ff};
      ridx_ext = {26'd0, ridx_ff};
      idx_ext  = {{(32 - CNT_W){1'b0}}, idx_ff};
      slot_ok  = slot_ext < 32'(SLOT_COUNT);
      var_ok   = var_ext >= 32'(VAR_BASE) && var_ext <= VAR_LAST;
      arg_ok   = rule_rd_ff.arg >= 32'(VAR_BASE) && rule_rd_ff.arg <= VAR_LAST;
      own_addr = 32'(slot_ext * 32'(VARIABLE_COUNT)) + var_ext - 32'(VAR_BASE);
      set_addr = 32'(idx_ext * 32'(VARIABLE_COUNT)) + var_ext - 32'(VAR_BASE);
      b_addr   = 32'(slot_ext * 32'(VARIABLE_COUNT)) + rule_rd_ff.arg - 32'(VAR_BASE);
      n_slots  = ({27'd0, aslots_ff} > 32'(SLOT_COUNT)) ? 32'(SLOT_COUNT)
                                                        : {27'd0, aslots_ff};
      n_rules  = ({25'd0, arules_ff} > 32'(RULE_DEPTH)) ? 32'(RULE_DEPTH)
                                                        : {25'd0, arules_ff};
      byte_val = byte_ok_ff ? store_rd_ff : 8'd0;
      b_op     = {24'd0, byte_val};
      c_op     = rule_rd_ff.arg;
   end

   // rule operations
   always_comb begin
      is_div   = 1'b0;
      want_rem = 1'b0;
      divisor  = c_op;
      case (rule_rd_ff.kind)
         KIND_DIV_C: begin
            is_div = 1'b1;
         end
         KIND_DIV_B: begin
            is_div  = 1'b1;
            divisor = b_op;
         end
         KIND_REM_B: begin
            is_div   = 1'b1;
            want_rem = 1'b1;
            divisor  = b_op;
         end
         KIND_REM_C: begin
            is_div   = 1'b1;
            want_rem = 1'b1;
         end
         default: begin
            is_div = 1'b0;
         end
      endcase

      mul_c   = 32'(acc_ff * c_op);
      mul_b   = 32'(acc_ff * b_op);
      alu_res = acc_ff;
      case (rule_rd_ff.kind)
         KIND_SRA_C: alu_res = $unsigned($signed(acc_ff) >>> c_op[4:0]);
         KIND_INV:   alu_res = ~acc_ff;
         KIND_SUB_C: alu_res = acc_ff - c_op;
         KIND_ADD_C: alu_res = acc_ff + c_op;
         KIND_SHL_C: alu_res = acc_ff << c_op[4:0];
         KIND_AND_C: alu_res = acc_ff & c_op;
         KIND_OR_C:  alu_res = acc_ff | c_op;
         KIND_SRA_B: alu_res = $unsigned($signed(acc_ff) >>> b_op[4:0]);
         KIND_SUB_B: alu_res = acc_ff - b_op;
         KIND_ADD_B: alu_res = acc_ff + b_op;
         KIND_SHL_B: alu_res = acc_ff << b_op[4:0];
         KIND_AND_B: alu_res = acc_ff & b_op;
         KIND_OR_B:  alu_res = acc_ff | b_op;
         KIND_MUL_C: alu_res = mul_c;
         KIND_MUL_B: alu_res = mul_b;
         KIND_B15: begin
            if ((acc_ff & BIT15) != 32'd0) begin
               alu_res = 32'd0 - (acc_ff & BYTE_MASK);
            end
         end
         KIND_ABS: begin
            if (acc_ff[31]) begin
               alu_res = 32'd0 - acc_ff;
            end
         end
         KIND_NEG: begin
            if (acc_ff != 32'd0 && !acc_ff[31]) begin
               alu_res = 32'd0 - acc_ff;
            end
         end
         default: alu_res = acc_ff;
      endcase
   end

   rcvt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (acc_ff),
      .divisor  (divisor),
      .want_rem (want_rem),
      .busy     (div_busy),
      .done     (div_done),
      .result   (div_result)
   );

   always_comb begin
      acc_in = acc_ff;
      if (cmd.load_req) begin
         acc_in = req_value;
      end else if (cmd.take_id && op_ff == OP_FETCH) begin
         acc_in = {{24{byte_val[7]}}, byte_val};
      end else if (cmd.exec) begin
         acc_in = alu_res;
      end else if (cmd.div_take) begin
         acc_in = div_result;
      end

      rsp_value_in = 32'd0;
      if (op_ff == OP_EVAL) begin
         rsp_value_in = acc_ff;
      end else if (op_ff == OP_FETCH && !rerr_ff) begin
         rsp_value_in = {{24{acc_ff[7]}}, acc_ff[7:0]};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         aslots_ff <= '0;
         arules_ff <= '0;
         found_ff  <= 1'b0;
         dz_ff     <= 1'b0;
         rerr_ff   <= 1'b0;
      end else begin
         if (cmd.load_req) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc || cmd.clr_wr) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (csr_wr && csr_index == CSR_ACTIVE_SLOTS) begin
            aslots_ff <= csr_data[4:0];
         end
         if (csr_wr && csr_index == CSR_ACTIVE_RULES) begin
            arules_ff <= csr_data[6:0];
         end
         if (cmd.load_req) begin
            found_ff <= 1'b0;
            dz_ff    <= 1'b0;
            rerr_ff  <= 1'b0;
         end else begin
            if (cmd.set_found) begin
               found_ff <= 1'b1;
            end
            if (cmd.set_rerr) begin
               rerr_ff <= 1'b1;
            end
            // exec on a divide kind only happens with a zero divisor
            if (cmd.exec && is_div) begin
               dz_ff <= 1'b1;
            end
         end
      end
   end

   // request capture, slot id, accumulator and response register
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= req_operation;
         slot_ff <= req_device_slot;
         dev_ff  <= req_sensor_id;
         var_ff  <= req_var_number;
         ridx_ff <= req_rule_index;
         kind_ff <= req_rule_kind;
         arg_ff  <= req_argument;
      end
      if (cmd.take_id) begin
         id_ff <= slot_rd_ff;
      end
      acc_ff <= acc_in;
      if (cmd.rsp_load) begin
         rsp_value_ff <= rsp_value_in;
         rsp_found_ff <= found_ff;
         rsp_dz_ff    <= dz_ff;
         rsp_rerr_ff  <= rerr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rule_wr && ridx_ext < 32'(RULE_DEPTH)) begin
         rule_mem[ridx_ext[RULE_AW-1:0]] <= '{var_num: var_ff, dev: dev_ff,
                                               kind: kind_ff, arg: arg_ff};
      end
      if (cmd.rule_rd) begin
         rule_rd_ff <= rule_mem[idx_ff[RULE_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.bind_wr && slot_ok) begin
         slot_mem[slot_ext[SLOT_AW-1:0]] <= dev_ff;
      end
      if (cmd.slot_rd) begin
         slot_rd_ff <= cmd.slot_search ? slot_mem[idx_ff[SLOT_AW-1:0]]
                                       : slot_mem[slot_ext[SLOT_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         store_mem[idx_ff[STORE_AW-1:0]] <= 8'd0;
      end else if (cmd.store_wr && var_ok) begin
         store_mem[set_addr[STORE_AW-1:0]] <= acc_ff[7:0];
      end
      if (cmd.byte_rd_own) begin
         store_rd_ff <= store_mem[own_addr[STORE_AW-1:0]];
         byte_ok_ff  <= slot_ok && var_ok;
      end else if (cmd.b_rd) begin
         store_rd_ff <= store_mem[b_addr[STORE_AW-1:0]];
         byte_ok_ff  <= arg_ok;
      end
   end

   always_comb begin
      st            = '0;
      st.op         = op_ff;
      st.slot_ok    = slot_ok;
      st.var_ok     = var_ok;
      st.slots_none = (n_slots == 32'd0);
      st.slot_last  = (idx_ext == n_slots - 32'd1);
      st.slot_match = (slot_rd_ff == dev_ff);
      st.rules_none = (n_rules == 32'd0);
      st.rule_last  = (idx_ext == n_rules - 32'd1);
      st.rule_hit   = (rule_rd_ff.dev == id_ff) && (rule_rd_ff.var_num == var_ff);
      st.div_go     = is_div && (divisor != 32'd0);
      st.div_done   = div_done;
      st.div_busy   = div_busy;
      st.clr_last   = (idx_ext == 32'(STORE_DEPTH - 1));
   end

   assign rsp_result_value   = rsp_value_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;
   assign rsp_range_error    = rsp_rerr_ff;

endmodule

`default_nettype wire

// ===== rtl/rule_chain_value_transform_core.sv =====
// ---------------------------------------------------------------------------
// Rule chain value transform core
// Sensor value post-processor: per-slot rule chains over a signed value.
// ---------------------------------------------------------------------------
//  channel   dir  handshake        contents
//  req_chan  in   valid / ready    operation, slot, id, variable, value, rule
//  rsp_chan  out  valid / ready    result_value, found, divide_by_zero,
//                                  range_error
//  csr_chan  in   valid / ready    reg_index, wr_data (ready always high)
//
//  One request at a time. Set variable searches the active slots in turn;
//  evaluate and fetch pass over the rules in order, apply each matching rule
//  and send each division with a nonzero divisor to the serial divider.
//  After reset all SLOT_COUNT * VARIABLE_COUNT variable store entries (512 by
//  default) are cleared, with req_chan.ready low meanwhile.
//  A finished response waits in the output register; a new request is taken
//  meanwhile, and its own response waits until that register is free.
// ---------------------------------------------------------------------------
`default_nettype none

`include "rule_chain_value_transform_core_defines.svh"

module rule_chain_value_transform_core #(
   parameter int RULE_DEPTH     = 64,
   parameter int SLOT_COUNT     = 16,
   parameter int VARIABLE_COUNT = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   rcvt_req_if.sink   req_chan,
   rcvt_rsp_if.source rsp_chan,
   rcvt_csr_if.sink   csr_chan
);
   import rcvt_pkg::*;

   cmd_type     cmd;
   stat_type    st;
   logic [31:0] result_value;

   rcvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .st        (st),
      .cmd       (cmd)
   );

   rcvt_datapath #(
      .RULE_DEPTH     (RULE_DEPTH),
      .SLOT_COUNT     (SLOT_COUNT),
      .VARIABLE_COUNT (VARIABLE_COUNT)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .st                 (st),
      .req_operation      (req_chan.operation),
      .req_device_slot    (req_chan.device_slot),
      .req_sensor_id      (req_chan.sensor_id),
      .req_var_number     (req_chan.var_number),
      .req_value          ($unsigned(req_chan.value)),
      .req_rule_index     (req_chan.rule_index),
      .req_rule_kind      (req_chan.rule_kind),
      .req_argument       ($unsigned(req_chan.argument)),
      .csr_wr             (csr_chan.valid && csr_chan.ready),
      .csr_index          (csr_chan.reg_index),
      .csr_data           (csr_chan.wr_data),
      .rsp_result_value   (result_value),
      .rsp_found          (rsp_chan.found),
      .rsp_divide_by_zero (rsp_chan.divide_by_zero),
      .rsp_range_error    (rsp_chan.range_error)
   );

   assign rsp_chan.result_value = $signed(result_value);
   assign csr_chan.ready        = 1'b1;

   `RCVT_ASSERT_NEXT(a_busy_after_req, req_chan.valid && req_chan.ready, !req_chan.ready, "request taken but block still ready next cycle")
   `RCVT_ASSERT_SAME(a_div_start_idle, cmd.div_start, !st.div_busy, "divider started while busy")
   `RCVT_ASSERT_SAME(a_rsp_slot_free, cmd.rsp_load, !rsp_chan.valid || rsp_chan.ready, "response register overwritten")

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ---------------------------------------------------------------------------
// Rule chain value transform core testbench
// Drives bind, rule load, set variable, evaluate and fetch requests with random gaps
// on the req and rsp channels, predicts each response and checks it field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rcvt_pkg::*;

   localparam int N_RULES    = 64;
   localparam int N_SLOTS    = 16;
   localparam int N_VARS     = 32;
   localparam int STALL_MAX  = 20000;
   localparam int TAIL_WAIT  = 100;

   typedef struct packed {
      logic [2:0]  op;
      logic [3:0]  slot;
      logic [15:0] dev;
      logic [8:0]  var_num;
      logic [31:0] value;
      logic [5:0]  ridx;
      logic [4:0]  kind;
      logic [31:0] arg;
   } request_t;

   typedef struct packed {
      logic [31:0] value;
      logic        found;
      logic        dz;
      logic        rerr;
   } outcome_t;

   class transform_scoreboard;
      rule_type    rules[N_RULES];
      logic [15:0] slot_ids[N_SLOTS];
      logic [7:0]  bytes[N_SLOTS * N_VARS];
      int unsigned n_slots;
      int unsigned n_rules;
      outcome_t    expected_q[$];
      int          fails;

      function new();
         for (int i = 0; i < N_SLOTS * N_VARS; i++) bytes[i] = '0;
         n_slots = 0;
         n_rules = 0;
         fails   = 0;
      endfunction

      function void write_reg(logic [3:0] idx, logic [31:0] data);
         if (idx == CSR_ACTIVE_SLOTS) n_slots = {27'd0, data[4:0]};
         else if (idx == CSR_ACTIVE_RULES) n_rules = {25'd0, data[6:0]};
      endfunction

      function bit var_ok(logic [31:0] v);
         return v >= VAR_BASE && v <= VAR_BASE - 1 + N_VARS;
      endfunction

      function logic [31:0] byte_of(int unsigned slot, logic [31:0] v);
         if (slot >= N_SLOTS || !var_ok(v)) return '0;
         return {24'd0, bytes[slot * N_VARS + (v - VAR_BASE)]};
      endfunction

      function logic [31:0] divmod(logic [31:0] a, logic [31:0] b, bit want_rem);
         logic [31:0] ua, ub, q, r;
         ua = a[31] ? -a : a;
         ub = b[31] ? -b : b;
         q  = ua / ub;
         r  = ua % ub;
         if (want_rem) return a[31] ? -r : r;
         return (a[31] != b[31]) ? -q : q;
      endfunction

      function logic [31:0] walk(int unsigned slot, logic [8:0] vn, logic [31:0] v,
                                 inout logic dz);
         int unsigned n;
         logic [15:0] id;
         logic [31:0] c, b;
         n = (n_rules > N_RULES) ? N_RULES : n_rules;
         if (slot >= N_SLOTS) return v;
         id = slot_ids[slot];
         for (int i = 0; i < n; i++) begin
            if (rules[i].dev != id || rules[i].var_num != vn) continue;
            c = rules[i].arg;
            b = byte_of(slot, c);
            case (rules[i].kind)
               KIND_SRA_C: v = $signed(v) >>> c[4:0];
               KIND_INV:   v = ~v;
               KIND_SUB_C: v = v - c;
               KIND_ADD_C: v = v + c;
               KIND_SHL_C: v = v << c[4:0];
               KIND_AND_C: v = v & c;
               KIND_OR_C:  v = v | c;
               KIND_SRA_B: v = $signed(v) >>> b[4:0];
               KIND_SUB_B: v = v - b;
               KIND_ADD_B: v = v + b;
               KIND_SHL_B: v = v << b[4:0];
               KIND_AND_B: v = v & b;
               KIND_OR_B:  v = v | b;
               KIND_MUL_C: v = v * c;
               KIND_DIV_C: if (c == 0) dz = 1'b1; else v = divmod(v, c, 1'b0);
               KIND_MUL_B: v = v * b;
               KIND_DIV_B: if (b == 0) dz = 1'b1; else v = divmod(v, b, 1'b0);
               KIND_B15:   if ((v & BIT15) != 0) v = -(v & BYTE_MASK);
               KIND_REM_B: if (b == 0) dz = 1'b1; else v = divmod(v, b, 1'b1);
               KIND_REM_C: if (c == 0) dz = 1'b1; else v = divmod(v, c, 1'b1);
               KIND_ABS:   if (v[31]) v = -v;
               KIND_NEG:   if (v != 0 && !v[31]) v = -v;
               default: ;
            endcase
         end
         return v;
      endfunction

      function void note_request(request_t rq);
         outcome_t    o;
         int unsigned n;
         logic [31:0] sx, r;
         o = '0;
         case (rq.op)
            OP_BIND: slot_ids[rq.slot] = rq.dev;
            OP_RULE: begin
               rules[rq.ridx].var_num = rq.var_num;
               rules[rq.ridx].dev     = rq.dev;
               rules[rq.ridx].kind    = rq.kind;
               rules[rq.ridx].arg     = rq.arg;
            end
            OP_SET: begin
               n = (n_slots > N_SLOTS) ? N_SLOTS : n_slots;
               for (int i = 0; i < n; i++) begin
                  if (slot_ids[i] == rq.dev) begin
                     o.found = 1'b1;
                     if (var_ok(rq.var_num))
                        bytes[i * N_VARS + (rq.var_num - VAR_BASE)] = rq.value[7:0];
                     break;
                  end
               end
            end
            OP_EVAL: o.value = walk(rq.slot, rq.var_num, rq.value, o.dz);
            OP_FETCH: begin
               if (var_ok(rq.var_num)) begin
                  sx = byte_of(rq.slot, rq.var_num);
                  sx = {{24{sx[7]}}, sx[7:0]};
                  r  = walk(rq.slot, rq.var_num, sx, o.dz);
                  o.value = {{24{r[7]}}, r[7:0]};
               end else begin
                  o.rerr = 1'b1;
               end
            end
            default: ;
         endcase
         expected_q.push_back(o);
      endfunction

      function void check_response(outcome_t got);
         outcome_t e;
         if (expected_q.size() == 0) begin
            $error("response with no request outstanding: value %h", got.value);
            fails++;
            return;
         end
         e = expected_q.pop_front();
         if (got.value !== e.value) begin
            $error("result_value expected %h got %h", e.value, got.value);
            fails++;
         end
         if (got.found !== e.found) begin
            $error("found expected %b got %b", e.found, got.found);
            fails++;
         end
         if (got.dz !== e.dz) begin
            $error("divide_by_zero expected %b got %b", e.dz, got.dz);
            fails++;
         end
         if (got.rerr !== e.rerr) begin
            $error("range_error expected %b got %b", e.rerr, got.rerr);
            fails++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   rcvt_req_if req();
   rcvt_rsp_if rsp();
   rcvt_csr_if csr();

   rule_chain_value_transform_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp),
      .csr_chan (csr)
   );

   transform_scoreboard sb = new();
   logic [15:0] id_pool[4] = '{16'h0011, 16'h0022, 16'h0033, 16'hFFFF};
   logic [8:0]  var_pool[6] = '{9'd257, 9'd258, 9'd288, 9'd259, 9'd5, 9'd0};
   bit  busy_sink = 1'b1;
   bit  busy_source = 1'b1;
   int  stall_count = 0;

   always #5 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.operation = '0;
      req.device_slot = '0;
      req.sensor_id = '0;
      req.var_number = '0;
      req.value = '0;
      req.rule_index = '0;
      req.rule_kind = '0;
      req.argument = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.reg_index = '0;
      csr.wr_data = '0;
   end

   // watchdog: no handshake on any channel for too long
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
         stall_count <= 0;
      else
         stall_count <= stall_count + 1;
      if (stall_count > STALL_MAX) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // response side
   initial begin
      outcome_t got;
      @(negedge clock);
      forever begin
         repeat (busy_sink ? $urandom_range(0, 4) : 0) begin
            rsp.ready = 1'b0;
            @(negedge clock);
         end
         rsp.ready = 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
         got.value = rsp.result_value;
         got.found = rsp.found;
         got.dz    = rsp.divide_by_zero;
         got.rerr  = rsp.range_error;
         sb.check_response(got);
         @(negedge clock);
      end
   end

   task automatic send_request(request_t rq);
      repeat (busy_source ? $urandom_range(0, 4) : 0) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.operation   = rq.op;
      req.device_slot = rq.slot;
      req.sensor_id   = rq.dev;
      req.var_number  = rq.var_num;
      req.value       = rq.value;
      req.rule_index  = rq.ridx;
      req.rule_kind   = rq.kind;
      req.argument    = rq.arg;
      req.valid       = 1'b1;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_request(rq);
      @(negedge clock);
   endtask

   task automatic drain;
      req.valid = 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(logic [3:0] idx, logic [31:0] data);
      csr.reg_index = idx;
      csr.wr_data   = data;
      csr.valid     = 1'b1;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr.valid = 1'b0;
   endtask

   function automatic request_t make_req(logic [2:0] op, logic [3:0] slot, logic [15:0] dev,
                                         logic [8:0] vn, logic [31:0] val, logic [5:0] ridx,
                                         logic [4:0] kind, logic [31:0] arg);
      request_t rq;
      rq = '{op, slot, dev, vn, val, ridx, kind, arg};
      return rq;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         3: return 32'h7FFF_FFFF;
         4: return $urandom_range(0, 40);
         default: return -$urandom_range(0, 40);
      endcase
   endfunction

   function automatic request_t random_req();
      request_t     rq;
      logic [127:0] raw;
      int           r;
      bit           byte_kind;
      raw = {$urandom, $urandom, $urandom, $urandom};
      rq  = raw[$bits(request_t)-1:0];
      r   = $urandom_range(0, 99);
      if (r < 5) rq.op = OP_BIND;
      else if (r < 20) rq.op = OP_RULE;
      else if (r < 38) rq.op = OP_SET;
      else if (r < 78) rq.op = OP_EVAL;
      else if (r < 95) rq.op = OP_FETCH;
      else rq.op = 3'(5 + $urandom_range(0, 2));
      if ($urandom_range(0, 9) != 0) rq.dev = id_pool[$urandom_range(0, 3)];
      if ($urandom_range(0, 9) != 0) begin
         rq.var_num = var_pool[$urandom_range(0, 5)];
         if ($urandom_range(0, 3) == 0) rq.var_num = 9'(VAR_BASE + $urandom_range(0, N_VARS));
      end
      rq.value = pick_word();
      byte_kind = rq.kind inside {KIND_SRA_B, KIND_SUB_B, KIND_ADD_B, KIND_SHL_B, KIND_AND_B,
                                  KIND_OR_B, KIND_MUL_B, KIND_DIV_B, KIND_REM_B};
      if (byte_kind && $urandom_range(0, 4) != 0)
         rq.arg = VAR_BASE - 1 + $urandom_range(0, N_VARS + 1);
      else
         rq.arg = pick_word();
      return rq;
   endfunction

   initial begin
      int unsigned cfg_slots[6] = '{16, 3, 31, 0, 1, 16};
      int unsigned cfg_rules[6] = '{64, 5, 127, 0, 1, 64};
      logic [4:0]  k;
      logic [31:0] a;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // every slot and rule entry written before anything reads them
      for (int i = 0; i < N_SLOTS; i++)
         send_request(make_req(OP_BIND, 4'(i), (i == 0) ? id_pool[0] : 16'(16'h1000 + i),
                               '0, '0, '0, '0, '0));
      for (int i = 0; i < N_RULES; i++) begin
         k = (i < 24) ? 5'(i) : KIND_SRA_C;
         case (k)
            KIND_SRA_C, KIND_SHL_C: a = 33;      // shift amount wraps mod 32
            KIND_SRA_B:             a = 400;     // bad reference reads zero
            KIND_DIV_C:             a = 0;
            KIND_DIV_B:             a = 260;     // unset in directed tests: zero divisor
            KIND_REM_C:             a = -7;
            KIND_MUL_C:             a = 3;
            KIND_SUB_B, KIND_ADD_B, KIND_SHL_B, KIND_AND_B, KIND_OR_B, KIND_MUL_B,
            KIND_REM_B:             a = 258;
            default:                a = 32'h0000_F0F5;
         endcase
         if (i == 24) begin k = KIND_DIV_C; a = 32'hFFFF_FFFF; end
         if (i == 25) begin k = KIND_REM_C; a = 32'hFFFF_FFFF; end
         if (i == 26) k = 5'd31;
         send_request(make_req(OP_RULE, '0, (i < 27) ? id_pool[0] : 16'hBEEF,
                               9'(i), '0, 6'(i), k, a));
      end
      drain();
      write_reg(CSR_ACTIVE_SLOTS, 16);
      write_reg(CSR_ACTIVE_RULES, 64);

      // directed: stored bytes, each kind once, corner values
      send_request(make_req(OP_SET, '0, id_pool[0], 9'd258, 32'h0000_0005, '0, '0, '0));
      send_request(make_req(OP_SET, '0, id_pool[0], 9'd288, 32'hFFFF_FF80, '0, '0, '0));
      send_request(make_req(OP_SET, '0, id_pool[0], 9'd300, 32'h55, '0, '0, '0));
      send_request(make_req(OP_SET, '0, 16'h4242, 9'd257, 32'h55, '0, '0, '0));
      for (int i = 0; i < 27; i++)
         send_request(make_req(OP_EVAL, '0, '0, 9'(i),
                               (i % 2) ? 32'h8000_0000 : 32'h7FFF_80F3, '0, '0, '0));
      send_request(make_req(OP_FETCH, '0, '0, 9'd288, '0, '0, '0, '0));
      send_request(make_req(OP_FETCH, '0, '0, 9'd256, '0, '0, '0, '0));
      send_request(make_req(OP_FETCH, 4'hF, '0, 9'd289, '0, '0, '0, '0));
      send_request(make_req(3'd7, 4'hF, 16'hFFFF, 9'h1FF, 32'hFFFF_FFFF, 6'h3F, 5'h1F,
                            32'hFFFF_FFFF));

      for (int p = 0; p < 6; p++) begin
         drain();
         write_reg(CSR_ACTIVE_SLOTS, cfg_slots[p]);
         write_reg(CSR_ACTIVE_RULES, cfg_rules[p]);
         busy_source = (p != 4);
         busy_sink   = (p != 4);
         for (int n = 0; n < 325; n++) begin
            if (p == 2 && n == 160) drain();   // let everything outstanding come home
            send_request(random_req());
         end
      end

      drain();
      repeat (TAIL_WAIT) @(negedge clock);
      if (sb.fails == 0 && sb.expected_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/rcvt_pkg.sv
rtl/rcvt_channels.sv
rtl/rcvt_div.sv
rtl/rcvt_ctrl.sv
rtl/rcvt_datapath.sv
rtl/rule_chain_value_transform_core.sv
sim/tb.sv
